/* hw/rtl/dfr_pkg.sv */
// ---------------------------------------------------------------------------
// dfr_pkg
// Shared widths, mode codes and digit constants for the decimal rounder.
// ---------------------------------------------------------------------------
package dfr_pkg;

  // digit counts and the kept-digit register are 5 bits wide (0..31)
  localparam int CNT_W = 5;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [1:0]       mode_t;
  typedef logic [3:0]       digit_t;

  // rounding modes; code 3 behaves as half even
  localparam mode_t MODE_HALF_UP   = 2'd0;
  localparam mode_t MODE_TRUNCATE  = 2'd1;
  localparam mode_t MODE_HALF_EVEN = 2'd2;

  localparam digit_t DIGIT_ZERO = 4'd0;
  localparam digit_t DIGIT_ONE  = 4'd1;
  localparam digit_t DIGIT_FIVE = 4'd5;
  localparam digit_t DIGIT_NINE = 4'd9;

  localparam count_t KEPT_RESET = 5'd2;

endpackage

/* hw/rtl/dfr_round.sv */
// ---------------------------------------------------------------------------
// dfr_round
// Combinational BCD rounding: round digit, sticky, parity, carry chain.
// ---------------------------------------------------------------------------
module dfr_round #(
  parameter int DIGITS = 16
) (
  input  dfr_pkg::mode_t           mode,
  input  logic [4*DIGITS-1:0]      integer_bcd,
  input  dfr_pkg::count_t          integer_count,
  input  logic [4*DIGITS-1:0]      fraction_bcd,
  input  dfr_pkg::count_t          fraction_count,
  input  logic                     beyond_nonzero,
  input  dfr_pkg::count_t          kept,
  output logic [4*DIGITS-1:0]      rounded_integer_bcd,
  output dfr_pkg::count_t          rounded_integer_count,
  output logic                     leading_one,
  output logic [4*DIGITS-1:0]      rounded_fraction_bcd
);

  localparam int              DW         = 4 * DIGITS;
  localparam dfr_pkg::count_t DIGITS_CNT = dfr_pkg::CNT_W'(DIGITS);

  dfr_pkg::count_t ic, fc, k;
  dfr_pkg::digit_t ipart [DIGITS];
  dfr_pkg::digit_t fpart [DIGITS];
  logic [DIGITS-1:0] fcarry_in;
  logic [DIGITS-1:0] icarry_in;
  dfr_pkg::digit_t check;
  logic sticky, parity, up, c;

  always_comb begin
    ic = (integer_count  > DIGITS_CNT) ? DIGITS_CNT : integer_count;
    fc = (fraction_count > DIGITS_CNT) ? DIGITS_CNT : fraction_count;
    k  = (kept           > DIGITS_CNT) ? DIGITS_CNT : kept;

    // digits outside the counts read as zero
    for (int i = 0; i < DIGITS; i++) begin
      ipart[i] = (dfr_pkg::CNT_W'(i) < ic) ? integer_bcd[4*i +: 4] : dfr_pkg::DIGIT_ZERO;
      fpart[i] = (dfr_pkg::CNT_W'(i) < fc) ? fraction_bcd[DW-4-4*i +: 4]
                                          : dfr_pkg::DIGIT_ZERO;
    end

    // no kept fraction digits: parity from integer units (zero if absent)
    check  = dfr_pkg::DIGIT_ZERO;
    sticky = beyond_nonzero;
    parity = ipart[0][0];
    for (int i = 0; i < DIGITS; i++) begin
      if (dfr_pkg::CNT_W'(i) == k) check = fpart[i];
      if (dfr_pkg::CNT_W'(i) > k && fpart[i] != dfr_pkg::DIGIT_ZERO) sticky = 1'b1;
      if (dfr_pkg::CNT_W'(i) + dfr_pkg::CNT_W'(1) == k) parity = fpart[i][0];
    end

    case (mode)
      dfr_pkg::MODE_TRUNCATE: up = 1'b0;
      dfr_pkg::MODE_HALF_UP:  up = (check >= dfr_pkg::DIGIT_FIVE);
      default: up = (check > dfr_pkg::DIGIT_FIVE) ||
                    ((check == dfr_pkg::DIGIT_FIVE) && (sticky || parity));
    endcase

    // carry ripples from the last kept fraction digit up through the integer
    c = up;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      fcarry_in[i] = c;
      if (dfr_pkg::CNT_W'(i) < k) c = c && (fpart[i] >= dfr_pkg::DIGIT_NINE);
    end
    for (int i = 0; i < DIGITS; i++) begin
      icarry_in[i] = c;
      if (dfr_pkg::CNT_W'(i) < ic) c = c && (ipart[i] >= dfr_pkg::DIGIT_NINE);
    end
    leading_one = c;

    for (int i = 0; i < DIGITS; i++) begin
      if (dfr_pkg::CNT_W'(i) < k) begin
        if (fcarry_in[i]) begin
          rounded_fraction_bcd[DW-4-4*i +: 4] = (fpart[i] >= dfr_pkg::DIGIT_NINE) ?
              dfr_pkg::DIGIT_ZERO : fpart[i] + dfr_pkg::DIGIT_ONE;
        end else begin
          rounded_fraction_bcd[DW-4-4*i +: 4] = fpart[i];
        end
      end else begin
        rounded_fraction_bcd[DW-4-4*i +: 4] = dfr_pkg::DIGIT_ZERO;
      end
      // ipart is already zero above ic
      if (icarry_in[i] && dfr_pkg::CNT_W'(i) < ic) begin
        rounded_integer_bcd[4*i +: 4] = (ipart[i] >= dfr_pkg::DIGIT_NINE) ?
            dfr_pkg::DIGIT_ZERO : ipart[i] + dfr_pkg::DIGIT_ONE;
      end else begin
        rounded_integer_bcd[4*i +: 4] = ipart[i];
      end
    end

    rounded_integer_count = ic;
  end

endmodule

/* hw/rtl/decimal_fraction_rounder_core.sv */
// ---------------------------------------------------------------------------
// decimal_fraction_rounder_core
// Rounds a BCD fixed-point number to a configured count of fraction digits.
// ---------------------------------------------------------------------------
// Path: an input transfer lands in the input register, then in the result
//   register after the rounding logic.
// Throughput: one item per cycle while the result side does not stall; the
//   single-pass BCD carry chain between the two registers sets the clock period.
// Reset (rst_n, synchronous, active low): pipeline empties, kept digit
//   count returns to 2.
module decimal_fraction_rounder_core #(
  parameter int DIGITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_we,
  input  dfr_pkg::count_t       cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dfr_pkg::mode_t        in_mode,
  input  logic [4*DIGITS-1:0]   in_integer_bcd,
  input  dfr_pkg::count_t       in_integer_count,
  input  logic [4*DIGITS-1:0]   in_fraction_bcd,
  input  dfr_pkg::count_t       in_fraction_count,
  input  logic                  in_beyond_nonzero,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4*DIGITS-1:0]   out_rounded_integer_bcd,
  output dfr_pkg::count_t       out_rounded_integer_count,
  output logic                  out_leading_one,
  output logic [4*DIGITS-1:0]   out_rounded_fraction_bcd
);

  localparam int DW = 4 * DIGITS;

  // kept fraction digits register
  dfr_pkg::count_t kept_r;

  // stage 1: captured input
  logic              s1_valid_r;
  dfr_pkg::mode_t    s1_mode_r;
  logic [DW-1:0]     s1_int_r;
  dfr_pkg::count_t   s1_icnt_r;
  logic [DW-1:0]     s1_frac_r;
  dfr_pkg::count_t   s1_fcnt_r;
  logic              s1_beyond_r;

  // stage 2: result register
  logic              out_valid_r;
  logic [DW-1:0]     out_int_r,  out_int_nxt;
  dfr_pkg::count_t   out_icnt_r, out_icnt_nxt;
  logic              out_lead_r, out_lead_nxt;
  logic [DW-1:0]     out_frac_r, out_frac_nxt;

  logic out_load;   // result register may take a new value
  logic s1_load;    // input register may take a new transfer

  // Elastic two-stage pipe: each stage advances whenever the stage ahead
  // is empty or is moving, so a waiting result blocks a new transfer only
  // once stage 1 is full as well.
  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= dfr_pkg::KEPT_RESET;
    end else if (cfg_we) begin
      kept_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_mode_r   <= in_mode;
      s1_int_r    <= in_integer_bcd;
      s1_icnt_r   <= in_integer_count;
      s1_frac_r   <= in_fraction_bcd;
      s1_fcnt_r   <= in_fraction_count;
      s1_beyond_r <= in_beyond_nonzero;
    end
  end

  // rounding between the two registers
  dfr_round #(
    .DIGITS(DIGITS)
  ) u_round (
    .mode                  (s1_mode_r),
    .integer_bcd           (s1_int_r),
    .integer_count         (s1_icnt_r),
    .fraction_bcd          (s1_frac_r),
    .fraction_count        (s1_fcnt_r),
    .beyond_nonzero        (s1_beyond_r),
    .kept                  (kept_r),
    .rounded_integer_bcd   (out_int_nxt),
    .rounded_integer_count (out_icnt_nxt),
    .leading_one           (out_lead_nxt),
    .rounded_fraction_bcd  (out_frac_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_int_r  <= out_int_nxt;
      out_icnt_r <= out_icnt_nxt;
      out_lead_r <= out_lead_nxt;
      out_frac_r <= out_frac_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_rounded_integer_bcd   = out_int_r;
  assign out_rounded_integer_count = out_icnt_r;
  assign out_leading_one           = out_lead_r;
  assign out_rounded_fraction_bcd  = out_frac_r;

  // an accepted transfer always lands in stage 1
  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("input transfer not captured");

  // a stage-1 item that cannot advance is kept
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_int_r) && $stable(s1_frac_r))
    else $error("stage 1 item lost while result stalled");

  // a carry out of all integer digits leaves every integer digit zero
  a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lead_r |-> out_int_r == '0)
    else $error("leading one with nonzero integer digits");

endmodule

/* dv/decimal_fraction_rounder_core_tb.sv */
// ---------------------------------------------------------------------------
// decimal_fraction_rounder_core_tb
// Self-checking bench for the BCD rounder: a directed table of corner numbers
// followed by biased random numbers over several kept-digit settings, each
// result checked field by field against a hand-worked or in-bench model answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_fraction_rounder_core_tb;

  localparam int NDIG         = 16;
  localparam int DRAIN_CYCLES = 4;    // pipeline is two deep; a little margin
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 145;
  localparam int PRINT_CAP    = 50;

  // code 3 is not named in the package; the block treats it as half even
  localparam dfr_pkg::mode_t MODE_ALT_EVEN = 2'd3;

  typedef struct packed {
    dfr_pkg::mode_t  mode;
    logic [63:0]     ibcd;
    dfr_pkg::count_t icnt;
    logic [63:0]     fbcd;
    dfr_pkg::count_t fcnt;
    logic            beyond;
  } num_item_t;

  typedef struct packed {
    logic [63:0]     int_bcd;
    dfr_pkg::count_t int_cnt;
    logic            lead;
    logic [63:0]     frac_bcd;
  } rounded_t;

  typedef struct packed {
    dfr_pkg::count_t kept;
    num_item_t       item;
    logic            typed;    // want holds a hand-written answer
    rounded_t        want;
  } corner_row_t;

  // all block inputs start at known values
  logic            clk               = 1'b0;
  logic            rst_n             = 1'b0;
  logic            cfg_we            = 1'b0;
  dfr_pkg::count_t cfg_data          = '0;
  logic            in_valid          = 1'b0;
  dfr_pkg::mode_t  in_mode           = dfr_pkg::MODE_HALF_UP;
  logic [63:0]     in_integer_bcd    = '0;
  dfr_pkg::count_t in_integer_count  = '0;
  logic [63:0]     in_fraction_bcd   = '0;
  dfr_pkg::count_t in_fraction_count = '0;
  logic            in_beyond_nonzero = 1'b0;
  logic            out_stall         = 1'b0;

  logic            in_stall;
  logic            out_valid;
  logic [63:0]     out_rounded_integer_bcd;
  dfr_pkg::count_t out_rounded_integer_count;
  logic            out_leading_one;
  logic [63:0]     out_rounded_fraction_bcd;

  rounded_t        pending_rounds [$];   // expected results, oldest first
  corner_row_t     corner_rows [$];
  dfr_pkg::count_t kept_shadow    = dfr_pkg::KEPT_RESET;
  int              mismatch_count = 0;
  int              stall_left     = 0;
  bit              idle_on        = 1'b1;
  rounded_t        got_want;

  decimal_fraction_rounder_core #(.DIGITS(NDIG)) uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_data                  (cfg_data),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_mode                   (in_mode),
    .in_integer_bcd            (in_integer_bcd),
    .in_integer_count          (in_integer_count),
    .in_fraction_bcd           (in_fraction_bcd),
    .in_fraction_count         (in_fraction_count),
    .in_beyond_nonzero         (in_beyond_nonzero),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_rounded_integer_bcd   (out_rounded_integer_bcd),
    .out_rounded_integer_count (out_rounded_integer_count),
    .out_leading_one           (out_leading_one),
    .out_rounded_fraction_bcd  (out_rounded_fraction_bcd)
  );

  always #5 clk = ~clk;

  // Watchdog: far above the slowest legal run (every transfer waiting out the
  // longest gap and the longest stall, plus the drains between phases).
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Rounding model
  // -------------------------------------------------------------------------
  function automatic int sat_count(input dfr_pkg::count_t v);
    return (v > NDIG) ? NDIG : int'(v);
  endfunction

  function automatic rounded_t round_number(input num_item_t it,
                                            input dfr_pkg::count_t kept_raw);
    dfr_pkg::digit_t ip [NDIG];
    dfr_pkg::digit_t fp [NDIG];
    int              ic, fc, k, i;
    dfr_pkg::digit_t chk;
    logic            stk, par, up, cy;
    rounded_t        r;
    ic = sat_count(it.icnt);
    fc = sat_count(it.fcnt);
    k  = sat_count(kept_raw);
    // nibbles beyond the counts read as zero
    for (i = 0; i < NDIG; i++) begin
      ip[i] = (i < ic) ? it.ibcd[4*i +: 4] : dfr_pkg::DIGIT_ZERO;
      fp[i] = (i < fc) ? it.fbcd[60-4*i +: 4] : dfr_pkg::DIGIT_ZERO;
    end
    // rounding digit is the first dropped one; zero if nothing is dropped
    chk = (k < fc) ? fp[k] : dfr_pkg::DIGIT_ZERO;
    stk = it.beyond;
    for (i = k + 1; i < fc; i++)
      if (fp[i] != dfr_pkg::DIGIT_ZERO) stk = 1'b1;
    // half even with no kept fraction digits looks at the integer units digit
    if (k > 0) par = fp[k-1][0];
    else       par = (ic > 0) ? ip[0][0] : 1'b0;
    case (it.mode)
      dfr_pkg::MODE_TRUNCATE: up = 1'b0;
      dfr_pkg::MODE_HALF_UP:  up = (chk >= dfr_pkg::DIGIT_FIVE);
      default: up = (chk > dfr_pkg::DIGIT_FIVE) ||
                    ((chk == dfr_pkg::DIGIT_FIVE) && (stk || par));
    endcase
    // carry ripples through kept fraction digits, then the integer digits;
    // any nibble of nine or more wraps to zero
    cy = up;
    for (i = k; i > 0 && cy; i--) begin
      if (fp[i-1] < dfr_pkg::DIGIT_NINE) begin
        fp[i-1] = fp[i-1] + dfr_pkg::DIGIT_ONE;
        cy = 1'b0;
      end else begin
        fp[i-1] = dfr_pkg::DIGIT_ZERO;
      end
    end
    for (i = 0; i < ic && cy; i++) begin
      if (ip[i] < dfr_pkg::DIGIT_NINE) begin
        ip[i] = ip[i] + dfr_pkg::DIGIT_ONE;
        cy = 1'b0;
      end else begin
        ip[i] = dfr_pkg::DIGIT_ZERO;
      end
    end
    r = '0;
    for (i = 0; i < ic; i++) r.int_bcd[4*i +: 4] = ip[i];
    for (i = 0; i < k; i++)  r.frac_bcd[60-4*i +: 4] = fp[i];
    r.int_cnt = dfr_pkg::count_t'(ic);
    r.lead    = cy;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Random numbers: heavy on nines (long carries) and fives (ties), with a
  // few non-decimal nibbles and now and then a raw 64-bit pattern.
  // -------------------------------------------------------------------------
  function automatic logic [63:0] rand_digits();
    logic [63:0] v;
    int          i, r;
    v = '0;
    if ($urandom_range(0, 15) == 0) begin
      v = {$urandom, $urandom};
    end else begin
      for (i = 0; i < NDIG; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35)      v[4*i +: 4] = dfr_pkg::DIGIT_NINE;
        else if (r < 45) v[4*i +: 4] = dfr_pkg::DIGIT_FIVE;
        else if (r < 55) v[4*i +: 4] = dfr_pkg::DIGIT_ZERO;
        else if (r < 92) v[4*i +: 4] = dfr_pkg::digit_t'($urandom_range(0, 9));
        else             v[4*i +: 4] = dfr_pkg::digit_t'($urandom_range(10, 15));
      end
    end
    return v;
  endfunction

  // mostly legal counts, sometimes past 16 to hit saturation
  function automatic dfr_pkg::count_t rand_count();
    if ($urandom_range(0, 11) == 0) return dfr_pkg::count_t'($urandom_range(17, 31));
    return dfr_pkg::count_t'($urandom_range(0, NDIG));
  endfunction

  function automatic num_item_t rand_item();
    num_item_t it;
    it.mode   = dfr_pkg::mode_t'($urandom_range(0, 3));
    it.ibcd   = rand_digits();
    it.icnt   = rand_count();
    it.fbcd   = rand_digits();
    it.fcnt   = rand_count();
    it.beyond = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic add_corner(input dfr_pkg::count_t kept, input dfr_pkg::mode_t mode,
                            input logic [63:0] ib, input dfr_pkg::count_t ic,
                            input logic [63:0] fb, input dfr_pkg::count_t fc,
                            input logic bz, input logic typed,
                            input logic [63:0] w_ib, input dfr_pkg::count_t w_ic,
                            input logic w_lead, input logic [63:0] w_fb);
    corner_row_t row;
    row.kept          = kept;
    row.item.mode     = mode;
    row.item.ibcd     = ib;
    row.item.icnt     = ic;
    row.item.fbcd     = fb;
    row.item.fcnt     = fc;
    row.item.beyond   = bz;
    row.typed         = typed;
    row.want.int_bcd  = w_ib;
    row.want.int_cnt  = w_ic;
    row.want.lead     = w_lead;
    row.want.frac_bcd = w_fb;
    corner_rows.push_back(row);
  endtask

  // Present one number, hold it through stalls, log its expectation at the
  // transfer edge. Valid stays high afterwards so back-to-back numbers
  // stream without a bubble.
  task automatic offer_number(input num_item_t it, input rounded_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_integer_bcd    <= it.ibcd;
    in_integer_count  <= it.icnt;
    in_fraction_bcd   <= it.fbcd;
    in_fraction_count <= it.fcnt;
    in_beyond_nonzero <= it.beyond;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rounds.push_back(want);
  endtask

  // wait for the pipe to empty; set_kept below then loads a new kept-digit count
  task automatic drain_rounds();
    in_valid <= 1'b0;
    while (pending_rounds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_kept(input dfr_pkg::count_t v);
    drain_rounds();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    kept_shadow  = v;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker. Both sample at the
  // edge, so they see the values that decide the transfer.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0)
      stall_left = stall_left - 1;
    else if (idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 14);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rounds.size() == 0) begin
        report_mismatch("result with nothing pending", out_rounded_integer_bcd, '0);
      end else begin
        got_want = pending_rounds.pop_front();
        if (out_rounded_integer_bcd !== got_want.int_bcd)
          report_mismatch("integer digits", out_rounded_integer_bcd, got_want.int_bcd);
        if (out_rounded_integer_count !== got_want.int_cnt)
          report_mismatch("integer count", 64'(out_rounded_integer_count),
                          64'(got_want.int_cnt));
        if (out_leading_one !== got_want.lead)
          report_mismatch("leading one", 64'(out_leading_one), 64'(got_want.lead));
        if (out_rounded_fraction_bcd !== got_want.frac_bcd)
          report_mismatch("fraction digits", out_rounded_fraction_bcd, got_want.frac_bcd);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int              p, n;
    dfr_pkg::count_t kv;
    rounded_t        w;

    // Corner table. Rows with typed=1 carry an answer worked by hand; the
    // rest go through the model. The first rows run on the reset count of 2.
    // args: kept, mode, int, icnt, frac, fcnt, beyond | typed, want...
    add_corner(2, dfr_pkg::MODE_HALF_UP, 64'h1, 1, 64'h1250_0000_0000_0000, 3, 0,
               1, 64'h1, 1, 0, 64'h1300_0000_0000_0000);
    add_corner(2, dfr_pkg::MODE_TRUNCATE, 64'h99, 2, 64'h9999_0000_0000_0000, 4, 1,
               1, 64'h99, 2, 0, 64'h9900_0000_0000_0000);
    // all nines everywhere: carry runs off the top
    add_corner(2, dfr_pkg::MODE_HALF_UP, 64'h9999_9999_9999_9999, 16,
               64'h9990_0000_0000_0000, 3, 0,
               1, 64'h0, 16, 1, 64'h0);
    add_corner(2, dfr_pkg::MODE_HALF_UP, 64'h0, 0, 64'h0, 0, 0,
               1, 64'h0, 0, 0, 64'h0);
    // half even ties: even keep, sticky from flag, odd keep, sticky from digits
    add_corner(2, dfr_pkg::MODE_HALF_EVEN, 64'h7, 1, 64'h1250_0000_0000_0000, 3, 0,
               0, 0, 0, 0, 0);
    add_corner(2, dfr_pkg::MODE_HALF_EVEN, 64'h7, 1, 64'h1250_0000_0000_0000, 3, 1,
               0, 0, 0, 0, 0);
    add_corner(2, dfr_pkg::MODE_HALF_EVEN, 64'h7, 1, 64'h1350_0000_0000_0000, 3, 0,
               0, 0, 0, 0, 0);
    add_corner(2, MODE_ALT_EVEN, 64'h7, 1, 64'h1250_0001_0000_0000, 8, 0,
               0, 0, 0, 0, 0);
    // fewer fraction digits than kept; junk nibbles outside the counts
    add_corner(2, dfr_pkg::MODE_HALF_UP, 64'hFFFF_FFFF_FFFF_FF12, 2,
               64'h9FFF_FFFF_FFFF_FFFF, 1, 0,
               1, 64'h12, 2, 0, 64'h9000_0000_0000_0000);
    // oversized counts and all-F nibbles
    add_corner(2, dfr_pkg::MODE_HALF_UP, '1, 31, '1, 31, 1,
               0, 0, 0, 0, 0);
    // non-decimal rounding digit and a non-decimal nibble in the carry path
    add_corner(2, dfr_pkg::MODE_HALF_EVEN, 64'hA3, 2, 64'h3BA0_0000_0000_0000, 3, 0,
               0, 0, 0, 0, 0);
    // no kept fraction digits: parity from integer units, or even if none
    add_corner(0, dfr_pkg::MODE_HALF_EVEN, 64'h2, 1, 64'h5000_0000_0000_0000, 1, 0,
               0, 0, 0, 0, 0);
    add_corner(0, dfr_pkg::MODE_HALF_EVEN, 64'h3, 1, 64'h5000_0000_0000_0000, 1, 0,
               0, 0, 0, 0, 0);
    add_corner(0, dfr_pkg::MODE_HALF_EVEN, 64'h0, 0, 64'h5000_0000_0000_0000, 1, 0,
               0, 0, 0, 0, 0);
    add_corner(0, dfr_pkg::MODE_HALF_EVEN, 64'h0, 0, 64'h5000_0000_0000_0000, 1, 1,
               0, 0, 0, 0, 0);
    add_corner(0, dfr_pkg::MODE_HALF_UP, 64'h9, 1, 64'h4999_9999_9999_9999, 16, 1,
               0, 0, 0, 0, 0);
    // all sixteen kept: nothing to round, digits pass through
    add_corner(16, dfr_pkg::MODE_HALF_UP, 64'h5, 1, 64'h1234_5678_9012_3456, 16, 1,
               0, 0, 0, 0, 0);
    add_corner(16, dfr_pkg::MODE_HALF_EVEN, 64'h0, 0, 64'hFEDC_BA98_7654_3210, 16, 0,
               1, 64'h0, 0, 0, 64'hFEDC_BA98_7654_3210);
    // register value past 16 saturates
    add_corner(31, dfr_pkg::MODE_HALF_UP, 64'h1, 1, 64'h9999_9999_9999_9999, 16, 1,
               0, 0, 0, 0, 0);
    // fifteen kept: round on the last digit, longest fraction carry
    add_corner(15, dfr_pkg::MODE_HALF_UP, 64'h9999, 4, 64'h9999_9999_9999_9995, 16, 0,
               1, 64'h0, 4, 1, 64'h0);
    add_corner(15, dfr_pkg::MODE_HALF_EVEN, 64'h1, 1, 64'h0000_0000_0000_0015, 16, 0,
               0, 0, 0, 0, 0);
    add_corner(1, dfr_pkg::MODE_TRUNCATE, 64'h8, 1, 64'h9900_0000_0000_0000, 2, 1,
               0, 0, 0, 0, 0);
    // carry out with no integer digits at all
    add_corner(1, dfr_pkg::MODE_HALF_UP, 64'h0, 0, 64'h9500_0000_0000_0000, 2, 0,
               0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < corner_rows.size(); n++) begin
      if (corner_rows[n].kept != kept_shadow) set_kept(corner_rows[n].kept);
      if (corner_rows[n].typed) w = corner_rows[n].want;
      else                      w = round_number(corner_rows[n].item, kept_shadow);
      offer_number(corner_rows[n].item, w);
    end

    // Random phases, one kept setting each; the last runs with no idling.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       kv = 0;
        1:       kv = 1;
        2:       kv = 16;
        3:       kv = 31;
        4:       kv = 15;
        5:       kv = 2;
        default: kv = dfr_pkg::count_t'($urandom_range(0, 31));
      endcase
      set_kept(kv);
      if (p == PHASES - 1) idle_on = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        num_item_t it;
        it = rand_item();
        offer_number(it, round_number(it, kept_shadow));
      end
    end

    drain_rounds();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
